### rtl/cst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and codes for the semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_DOWN    = 2'd2,
		CMD_UP      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_ID  = 3'd1,
		ST_FULL    = 3'd2,
		ST_BLOCKED = 3'd3,
		ST_NO_PROC = 3'd4,
		ST_QFULL   = 3'd5,
		ST_SAT     = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] target_id;
		logic [7:0] initial_count;
		logic [7:0] caller_pid;
		logic       caller_valid;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] created_id;
		logic [7:0] woken_pid;
		logic       woken_valid;
	} out_item_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_SEARCH,
		EX_READ,
		EX_EXEC,
		EX_OUT
	} ex_state_t;

	localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage
`default_nettype wire

### rtl/counting_semaphore_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Counting semaphore table with per-slot FIFO wait queues.
// ----------------------------------------------------------------------------
// A two-entry command queue decouples intake from execution. Each command
// passes through the execution unit's steps in order (accept, memory read,
// update, result); create instead walks the free-slot search one slot per
// cycle from the search pointer until it finds a free slot or the table is full.
// Results stay valid until taken.
module counting_semaphore_table_core #(
	parameter int SEM_SLOTS  = 32,
	parameter int WAIT_DEPTH = 8,
	parameter int PID_BITS   = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  cst_pkg::in_item_t  in_item,
	output logic              out_valid,
	input  wire               out_ready,
	output cst_pkg::out_item_t out_item
);
	import cst_pkg::*;

	logic     q_valid, q_ready;
	in_item_t q_item;

	cst_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	cst_back #(
		.SEM_SLOTS(SEM_SLOTS), .WAIT_DEPTH(WAIT_DEPTH), .PID_BITS(PID_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule
`default_nettype wire

### rtl/cst_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_front
// Accepts command transactions and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cst_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  cst_pkg::in_item_t in_item,
	output logic             q_valid,
	input  wire              q_ready,
	output cst_pkg::in_item_t q_item
);
	import cst_pkg::*;

	in_item_t  mem_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;

	wire push = in_valid && in_ready;
	wire pop  = q_valid && q_ready;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");

endmodule
`default_nettype wire

### rtl/cst_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_back
// Executes one command against the slot table and waiter memory.
// ----------------------------------------------------------------------------
module cst_back #(
	parameter int SEM_SLOTS  = 32,
	parameter int WAIT_DEPTH = 8,
	parameter int PID_BITS   = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_valid,
	output logic              q_ready,
	input  cst_pkg::in_item_t  q_item,
	output logic              out_valid,
	input  wire               out_ready,
	output cst_pkg::out_item_t out_item
);
	import cst_pkg::*;

	localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
	localparam int DW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FW = $clog2(WAIT_DEPTH + 1);
	localparam int TW = $clog2(SEM_SLOTS + 1);
	localparam int MW = SW + DW;
	localparam int PW = (PID_BITS < 8) ? PID_BITS : 8;

	logic [SEM_SLOTS-1:0] live_q;
	logic [7:0]           count_q [SEM_SLOTS];
	logic [DW-1:0]        head_q  [SEM_SLOTS];
	logic [FW-1:0]        fill_q  [SEM_SLOTS];
	logic [PW-1:0]        wmem    [SEM_SLOTS*WAIT_DEPTH];
	logic [SW-1:0]        sp_q;
	logic [TW-1:0]        total_q;

	ex_state_t  st_q, st_d;
	in_item_t   cur_q;
	out_item_t  res_q;
	logic [SW-1:0] p_q;
	logic [PW-1:0] rd_pid_q;

	wire [SW-1:0] id     = cur_q.target_id[SW-1:0];
	wire          id_ok  = ({27'd0, cur_q.target_id} < 32'(SEM_SLOTS)) && live_q[id];
	wire [7:0]    cnt    = count_q[id];
	wire [FW-1:0] fil    = fill_q[id];
	wire [DW-1:0] hd     = head_q[id];
	wire [DW:0]   tsum   = {1'b0, hd} + fil[DW:0];
	wire [DW-1:0] tail   = (tsum >= (DW+1)'(WAIT_DEPTH)) ?
		DW'(tsum - (DW+1)'(WAIT_DEPTH)) : tsum[DW-1:0];
	wire [DW:0]   hsum   = {1'b0, hd} + 1'b1;
	wire [DW-1:0] hnext  = (hsum == (DW+1)'(WAIT_DEPTH)) ? '0 : hsum[DW-1:0];
	wire [SW:0]   psum   = {1'b0, p_q} + 1'b1;
	wire [SW-1:0] pnext  = (psum == (SW+1)'(SEM_SLOTS)) ? '0 : psum[SW-1:0];
	wire [MW-1:0] rd_addr = MW'(id * WAIT_DEPTH + hd);
	wire [MW-1:0] wr_addr = MW'(id * WAIT_DEPTH + tail);

	wire is_down = (cmd_t'(cur_q.command) == CMD_DOWN);
	wire is_up   = (cmd_t'(cur_q.command) == CMD_UP);
	wire do_push = st_q == EX_EXEC && is_down && id_ok && cnt == 8'd0
		&& cur_q.caller_valid && fil < FW'(WAIT_DEPTH);

	assign q_ready   = (st_q == EX_IDLE);
	assign out_valid = (st_q == EX_OUT);
	assign out_item  = res_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			EX_IDLE: if (q_valid) begin
				st_d = (cmd_t'(q_item.command) == CMD_CREATE) ? EX_SEARCH : EX_READ;
			end
			EX_SEARCH: if (total_q >= TW'(SEM_SLOTS) || !live_q[p_q]) begin
				st_d = EX_OUT;
			end
			EX_READ: st_d = EX_EXEC;
			EX_EXEC: st_d = EX_OUT;
			EX_OUT:  if (out_ready) st_d = EX_IDLE;
			default: st_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) cur_q <= q_item;
		rd_pid_q <= wmem[rd_addr];
		if (do_push) wmem[wr_addr] <= cur_q.caller_pid[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE;
			live_q <= SEM_SLOTS'(1);
			for (int i = 0; i < SEM_SLOTS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				fill_q[i]  <= '0;
			end
			sp_q <= '0;
			total_q <= TW'(1);
			p_q <= '0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == EX_IDLE && q_valid) begin
				p_q <= sp_q;
				res_q <= '0;
			end
			if (st_q == EX_SEARCH) begin
				if (total_q >= TW'(SEM_SLOTS)) begin
					res_q.status <= ST_FULL;
				end else if (!live_q[p_q]) begin
					sp_q <= p_q;
					live_q[p_q] <= 1'b1;
					count_q[p_q] <= cur_q.initial_count;
					head_q[p_q] <= '0;
					fill_q[p_q] <= '0;
					total_q <= total_q + 1'b1;
					res_q.created_id <= 5'(p_q);
				end else begin
					p_q <= pnext;
				end
			end
			if (st_q == EX_EXEC) begin
				priority if (!id_ok) begin
					res_q.status <= ST_BAD_ID;
				end else if (!is_down && !is_up) begin
					live_q[id] <= 1'b0;
					head_q[id] <= '0;
					fill_q[id] <= '0;
					total_q <= total_q - 1'b1;
				end else if (is_down) begin
					priority if (cnt != 8'd0) count_q[id] <= cnt - 8'd1;
					else if (!cur_q.caller_valid) res_q.status <= ST_NO_PROC;
					else if (fil >= FW'(WAIT_DEPTH)) res_q.status <= ST_QFULL;
					else begin
						fill_q[id] <= fil + 1'b1;
						res_q.status <= ST_BLOCKED;
					end
				end else begin
					if (cnt == COUNT_MAX) res_q.status <= ST_SAT;
					else begin
						count_q[id] <= cnt + 8'd1;
						if (fil != '0) begin
							res_q.woken_pid <= 8'(rd_pid_q);
							res_q.woken_valid <= 1'b1;
							head_q[id] <= hnext;
							fill_q[id] <= fil - 1'b1;
						end
					end
				end
			end
		end
	end

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == TW'($countones(live_q))) else $error("live total mismatch");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q)) else $error("result lost");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_ready && out_valid)) else $error("accept during result");

endmodule
`default_nettype wire
